// ----- rtl/core/b64d_pkg.sv -----
// Package with the shared types, codes and the character lookup of the base64 decoder.
package b64d_pkg;

    // Message phase codes.
    localparam logic [1:0] PH_DATA = 2'd0;
    localparam logic [1:0] PH_PAD  = 2'd1;
    localparam logic [1:0] PH_DROP = 2'd2;

    // Configuration register indexes and the width of the APB address.
    localparam int unsigned ADDR_W = 2;
    localparam logic [ADDR_W-1:0] REG_PADDING_REQUIRED = 2'd0;

    // Character codes with a special meaning.
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // Decoder state carried from one character to the next.
    typedef struct packed {
        logic [5:0] held_symbol;
        logic [1:0] group_position;
        logic [1:0] phase;
        logic [1:0] pads_remaining;
    } t_state;

    // One result transaction.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
        logic       bad_input;
    } t_result;

    // Maps a character to {invalid, symbol}; invalid is set outside the alphabet.
    function automatic logic [6:0] symbol_of(input logic [7:0] c);
        logic [6:0] s;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = {1'b0, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = {1'b0, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = {1'b0, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            s = {1'b0, 6'd62};
        end else if (c == 8'h2F) begin
            s = {1'b0, 6'd63};
        end else begin
            s = {1'b1, 6'd0};
        end
        return s;
    endfunction

    // Number of '=' expected when the group holds pos symbols.
    function automatic logic [1:0] pads_for(input logic [1:0] pos);
        logic [1:0] n;
        case (pos)
            2'd2:    n = 2'd2;
            2'd3:    n = 2'd1;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// ----- rtl/core/b64d_if.sv -----
// Stream interfaces for the character input and the byte output of the decoder.
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
    logic       bad_input;

    modport source (output valid, output data_byte, output byte_valid,
                    output message_end, output bad_input, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input message_end, input bad_input, output ready);
endinterface

// ----- rtl/core/b64d_apb_regs.sv -----
// APB configuration register block holding the padding mode.
module b64d_apb_regs
    import b64d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic              o_padding_required
);

    logic r_padding_required;
    logic n_padding_required;

    // The register is written in the access phase of a write.
    always_comb begin
        n_padding_required = r_padding_required;
        if (psel && penable && pwrite && paddr == REG_PADDING_REQUIRED) begin
            n_padding_required = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_padding_required <= 1'b1;
        end else begin
            r_padding_required <= n_padding_required;
        end
    end

    // Read data and a port that never waits.
    assign prdata = (paddr == REG_PADDING_REQUIRED) ? {31'd0, r_padding_required} : 32'd0;
    assign pready = 1'b1;
    assign o_padding_required = r_padding_required;

endmodule

// ----- rtl/core/b64d_decode_step.sv -----
// Combinational decode of one character against the current message state.
module b64d_decode_step
    import b64d_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    input  logic       i_padding_required,
    output t_state     o_state,
    output logic       o_emit,
    output t_result    o_result
);

    localparam t_state CLEAR_STATE = '{held_symbol: 6'd0, group_position: 2'd0,
                                       phase: PH_DATA, pads_remaining: 2'd0};

    logic [6:0] sym_lookup;
    logic [5:0] sym;
    logic       sym_bad;
    logic [5:0] h;
    logic [1:0] pos_next;
    logic [1:0] need;
    logic [1:0] pads_dec;
    logic [7:0] byte_val;
    logic       byte_ok;
    logic       is_pad;
    logic       fail;
    logic       good_end;

    assign sym_lookup = symbol_of(i_char_code);
    assign sym_bad    = sym_lookup[6];
    assign sym        = sym_lookup[5:0];
    assign h          = i_state.held_symbol;
    assign pos_next   = i_state.group_position + 2'd1;
    assign need       = pads_for(i_state.group_position);
    assign is_pad     = (i_char_code == CHAR_PAD);

    // Byte assembled from the held symbol and the new one.
    always_comb begin
        byte_ok = 1'b1;
        case (i_state.group_position)
            2'd1:    byte_val = {h, sym[5:4]};
            2'd2:    byte_val = {h[3:0], sym[5:2]};
            2'd3:    byte_val = {h[1:0], sym};
            default: begin
                byte_val = 8'd0;
                byte_ok  = 1'b0;
            end
        endcase
    end

    // Phase handling: failures, padding count and good ends.
    always_comb begin
        fail     = 1'b0;
        good_end = 1'b0;
        pads_dec = 2'd0;
        o_state  = i_state;
        o_emit   = 1'b0;
        o_result = '0;
        case (i_state.phase)
            PH_DROP: begin
                if (i_last_char) begin
                    o_state = CLEAR_STATE;
                end
            end
            PH_PAD: begin
                pads_dec = i_state.pads_remaining - 2'd1;
                if (!is_pad || i_state.pads_remaining == 2'd0) begin
                    fail = 1'b1;
                end else begin
                    o_state.pads_remaining = pads_dec;
                    if (i_last_char) begin
                        if (pads_dec == 2'd0) begin
                            good_end = 1'b1;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                end
            end
            PH_DATA: begin
                if (is_pad) begin
                    pads_dec = need - 2'd1;
                    if (!i_padding_required || need == 2'd0) begin
                        fail = 1'b1;
                    end else begin
                        o_state.pads_remaining = pads_dec;
                        o_state.phase          = PH_PAD;
                        if (i_last_char) begin
                            if (pads_dec == 2'd0) begin
                                good_end = 1'b1;
                            end else begin
                                fail = 1'b1;
                            end
                        end
                    end
                end else if (sym_bad) begin
                    fail = 1'b1;
                end else begin
                    o_state.held_symbol    = sym;
                    o_state.group_position = pos_next;
                    if (i_last_char) begin
                        if (i_padding_required && pads_for(pos_next) != 2'd0) begin
                            fail = 1'b1;
                        end else begin
                            o_emit   = 1'b1;
                            o_result = '{data_byte: byte_val, byte_valid: byte_ok,
                                         message_end: 1'b1, bad_input: 1'b0};
                            o_state  = CLEAR_STATE;
                        end
                    end else if (byte_ok) begin
                        o_emit   = 1'b1;
                        o_result = '{data_byte: byte_val, byte_valid: 1'b1,
                                     message_end: 1'b0, bad_input: 1'b0};
                    end
                end
            end
            default: begin
                o_state = CLEAR_STATE;
            end
        endcase

        // A good end closes the message without a byte.
        if (good_end) begin
            o_emit   = 1'b1;
            o_result = '{data_byte: 8'd0, byte_valid: 1'b0, message_end: 1'b1, bad_input: 1'b0};
            o_state  = CLEAR_STATE;
        end

        // An error ends the message and drops the rest unless this was its last character.
        if (fail) begin
            o_emit   = 1'b1;
            o_result = '{data_byte: 8'd0, byte_valid: 1'b0, message_end: 1'b1, bad_input: 1'b1};
            o_state  = CLEAR_STATE;
            if (!i_last_char) begin
                o_state.phase = PH_DROP;
            end
        end
    end

endmodule

// ----- rtl/core/base64_decoder_checked_top.sv -----
// Top level of the streaming base64 decoder with strict padding checks.
//
//   Port group   Direction  Contents
//   i_char       in         char_code[7:0], last_char       (valid/ready)
//   o_byte       out        data_byte, byte_valid, message_end, bad_input (valid/ready)
//   APB          in/out     padding_required at address 0
//
// One character per cycle sustained while results are taken; a result is registered after its
// character passes the input register and is decoded into the result register.
// The decode of one character is a table lookup and a shift between those registers.
// Reset is synchronous and active low; it selects padded mode and the data phase.
// When the result register is full and not taken, the input register holds its
// character and the input deasserts ready once that register is occupied too.
module base64_decoder_checked_top
    import b64d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    b64d_in_if.sink           i_char,
    b64d_out_if.source        o_byte,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic       padding_required;

    logic       r_s1_valid;
    logic [7:0] r_s1_char;
    logic       r_s1_last;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_result;
    logic       n_emit;
    logic       out_free;
    logic       s1_advance;
    logic       in_take;

    // Configuration registers.
    b64d_apb_regs u_regs (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .o_padding_required (padding_required)
    );

    // Handshake control: the stage advances whenever the result slot is free or drains.
    assign out_free   = !r_out_valid || o_byte.ready;
    assign s1_advance = r_s1_valid && out_free;
    assign i_char.ready = !r_s1_valid || out_free;
    assign in_take    = i_char.valid && i_char.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_s1_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_char <= i_char.char_code;
            r_s1_last <= i_char.last_char;
        end
    end

    // Decode of the registered character.
    b64d_decode_step u_step (
        .i_state            (r_state),
        .i_char_code        (r_s1_char),
        .i_last_char        (r_s1_last),
        .i_padding_required (padding_required),
        .o_state            (n_state),
        .o_emit             (n_emit),
        .o_result           (n_result)
    );

    // Message state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{held_symbol: 6'd0, group_position: 2'd0,
                             phase: PH_DATA, pads_remaining: 2'd0};
            r_out_valid <= 1'b0;
        end else begin
            if (s1_advance) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= s1_advance && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && n_emit) begin
            r_out <= n_result;
        end
    end

    assign o_byte.valid       = r_out_valid;
    assign o_byte.data_byte   = r_out.data_byte;
    assign o_byte.byte_valid  = r_out.byte_valid;
    assign o_byte.message_end = r_out.message_end;
    assign o_byte.bad_input   = r_out.bad_input;

    // A character waiting on a stalled result is kept.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid)
        else $error("input register lost a character during a stall");

    // Input backpressure only comes from an occupied input register while the result register is full.
    a_ready_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_char.ready |-> r_s1_valid && r_out_valid)
        else $error("input not ready without a pending character");

    // Characters dropped after an error give no result.
    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance && r_state.phase == PH_DROP |=> !r_out_valid)
        else $error("result produced while dropping a message");

    // A rejected message carries no byte and closes the message.
    a_bad_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.bad_input |-> r_out.message_end && !r_out.byte_valid)
        else $error("error result without message end");

    // Any message end returns the decoder to the start of a group.
    a_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance && r_s1_last |=> r_state.group_position == 2'd0
                                   && r_state.phase == PH_DATA)
        else $error("state not cleared at message end");

endmodule

// ----- dv/base64_decoder_checked_top_tb.sv -----
// Self-checking testbench for the streaming base64 decoder: directed and random messages.
module base64_decoder_checked_top_tb;
    import b64d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_DIR      = 24;
    localparam int SETTLE     = 6;
    localparam int LONG_HOLD  = 120;
    localparam int MAX_PRINTS = 200;

    // Typed results for the rows whose outcome is plain to see.
    localparam t_result ERR_END  = '{data_byte: 8'h00, byte_valid: 1'b0,
                                     message_end: 1'b1, bad_input: 1'b1};
    localparam t_result GOOD_END = '{data_byte: 8'h00, byte_valid: 1'b0,
                                     message_end: 1'b1, bad_input: 1'b0};
    localparam t_result NO_RES   = '0;

    typedef enum int {MSG_CLEAN, MSG_SHORT_PAD, MSG_EXTRA, MSG_NOISE} t_msg_kind;

    typedef struct {
        logic [7:0] c;
        bit         last;
        bit         pad_mode;
        bit         typed;
        t_result    want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    b64d_in_if  char_if ();
    b64d_out_if byte_if ();

    base64_decoder_checked_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_byte  (byte_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Decoder state as the testbench tracks it.
    bit         pad_mode;
    logic [5:0] st_held;
    logic [1:0] st_pos;
    logic [1:0] st_phase;
    logic [1:0] st_pads;
    logic [6:0] sym_lut [0:255];

    t_result decoded_q [$];
    int      errors;
    int      live_items;
    int      hold_asked;
    int      hold_served;
    bit      calm_run;

    // Directed messages: padded mode first, then unpadded.
    t_dir_row dir_rows [N_DIR] = '{
        '{"T", 1'b0, 1'b1, 1'b0, NO_RES},
        '{"W", 1'b0, 1'b1, 1'b0, NO_RES},
        '{"F", 1'b0, 1'b1, 1'b0, NO_RES},
        '{"u", 1'b1, 1'b1, 1'b0, NO_RES},
        '{"T", 1'b0, 1'b1, 1'b0, NO_RES},
        '{"Q", 1'b0, 1'b1, 1'b0, NO_RES},
        '{"=", 1'b0, 1'b1, 1'b0, NO_RES},
        '{"=", 1'b1, 1'b1, 1'b1, GOOD_END},
        '{8'h00, 1'b0, 1'b1, 1'b1, ERR_END},
        '{8'h80, 1'b0, 1'b1, 1'b0, NO_RES},
        '{"A", 1'b1, 1'b1, 1'b0, NO_RES},
        '{"+", 1'b0, 1'b1, 1'b0, NO_RES},
        '{"/", 1'b1, 1'b1, 1'b1, ERR_END},
        '{"Q", 1'b0, 1'b1, 1'b0, NO_RES},
        '{"Q", 1'b0, 1'b1, 1'b0, NO_RES},
        '{"=", 1'b0, 1'b1, 1'b0, NO_RES},
        '{"=", 1'b0, 1'b1, 1'b0, NO_RES},
        '{"=", 1'b1, 1'b1, 1'b1, ERR_END},
        '{"A", 1'b0, 1'b1, 1'b0, NO_RES},
        '{"=", 1'b1, 1'b1, 1'b1, ERR_END},
        '{"z", 1'b0, 1'b0, 1'b0, NO_RES},
        '{"9", 1'b1, 1'b0, 1'b0, NO_RES},
        '{"=", 1'b1, 1'b0, 1'b1, ERR_END},
        '{8'hFF, 1'b1, 1'b0, 1'b1, ERR_END}
    };

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Alphabet character for a 6-bit symbol.
    function automatic logic [7:0] symbol_char(input logic [5:0] v);
        if (v < 6'd26) return 8'("A" + v);
        if (v < 6'd52) return 8'("a" + (v - 6'd26));
        if (v < 6'd62) return 8'("0" + (v - 6'd52));
        if (v == 6'd62) return "+";
        return "/";
    endfunction

    // Padding owed once the group holds pos symbols.
    function automatic logic [1:0] pads_owed(input logic [1:0] pos);
        if (pos == 2'd2) return 2'd2;
        if (pos == 2'd3) return 2'd1;
        return 2'd0;
    endfunction

    function automatic void clear_message_state();
        st_held  = '0;
        st_pos   = '0;
        st_phase = PH_DATA;
        st_pads  = '0;
    endfunction

    // Advances the tracked state by one character; returns 1 when a result is due.
    function automatic bit decode_step(input logic [7:0] c, input bit last,
                                       output t_result r);
        logic [6:0] lk;
        logic [7:0] b;
        bit         has_byte;
        bit         emit;
        bit         reject;
        r      = '0;
        emit   = 1'b0;
        reject = 1'b0;
        lk     = sym_lut[c];
        // A first '=' where padding is owed opens the padding phase.
        if (st_phase == PH_DATA && c == CHAR_PAD && pad_mode && pads_owed(st_pos) != 2'd0) begin
            st_phase = PH_PAD;
            st_pads  = pads_owed(st_pos);
        end
        if (st_phase == PH_DROP) begin
            if (last) clear_message_state();
        end else if (st_phase == PH_PAD) begin
            if (c != CHAR_PAD || st_pads == 2'd0) begin
                reject = 1'b1;
            end else begin
                st_pads = st_pads - 2'd1;
                if (last) begin
                    emit          = 1'b1;
                    r.message_end = 1'b1;
                    r.bad_input   = (st_pads != 2'd0);
                    clear_message_state();
                end
            end
        end else if (lk[6]) begin
            // Outside the alphabet, a stray '=' included.
            reject = 1'b1;
        end else begin
            case (st_pos)
                2'd1:    b = {st_held, lk[5:4]};
                2'd2:    b = {st_held[3:0], lk[5:2]};
                2'd3:    b = {st_held[1:0], lk[5:0]};
                default: b = 8'h00;
            endcase
            has_byte = (st_pos != 2'd0);
            st_held  = lk[5:0];
            st_pos   = st_pos + 2'd1;
            if (last) begin
                emit          = 1'b1;
                r.message_end = 1'b1;
                if (pad_mode && pads_owed(st_pos) != 2'd0) begin
                    r.bad_input = 1'b1;
                end else begin
                    r.data_byte  = b;
                    r.byte_valid = has_byte;
                end
                clear_message_state();
            end else if (has_byte) begin
                emit         = 1'b1;
                r.data_byte  = b;
                r.byte_valid = 1'b1;
            end
        end
        if (reject) begin
            emit = 1'b1;
            r    = ERR_END;
            clear_message_state();
            if (!last) st_phase = PH_DROP;
        end
        return emit;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Offers one character, waits for its transaction and records what it should cause.
    task automatic send_char(input logic [7:0] c, input bit last, input bit typed,
                             input t_result typed_r);
        int      gap;
        t_result r;
        bit      due;
        if (!calm_run && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= c;
        char_if.last_char <= last;
        do @(posedge i_clk); while (!char_if.ready);
        if (st_phase != PH_DROP) live_items++;
        due = decode_step(c, last, r);
        if (typed) decoded_q.push_back(typed_r);
        else if (due) decoded_q.push_back(r);
    endtask

    // Stops sending and lets every pending result and the pipeline drain.
    task automatic wait_idle();
        char_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes the padding register over APB and reads it back.
    task automatic set_padding_mode(input bit mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_PADDING_REQUIRED;
        pwdata  <= {31'b0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pad_mode = mode;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("prdata", prdata, {31'b0, mode});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One message: a clean encoding, a broken one, or noise.
    task automatic send_message(input t_msg_kind kind);
        logic [7:0] text [$];
        int         nsym;
        int         npad;
        int         n;
        int         pick;
        nsym = $urandom_range(1, 12);
        for (int i = 0; i < nsym; i++) text.push_back(symbol_char(6'($urandom_range(0, 63))));
        npad = pad_mode ? int'(pads_owed(2'(nsym % 4))) : 0;
        case (kind)
            MSG_CLEAN: begin
                for (int i = 0; i < npad; i++) text.push_back(CHAR_PAD);
            end
            MSG_SHORT_PAD: begin
                if (npad == 0) text.push_back(CHAR_PAD);
                for (int i = 1; i < npad; i++) text.push_back(CHAR_PAD);
            end
            MSG_EXTRA: begin
                for (int i = 0; i < npad; i++) text.push_back(CHAR_PAD);
                pick = $urandom_range(0, 2);
                if (pick == 0) text.push_back(CHAR_PAD);
                else if (pick == 1) text.push_back(symbol_char(6'($urandom_range(0, 63))));
                else text.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                text.delete();
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4) text.push_back(symbol_char(6'($urandom_range(0, 63))));
                    else if (pick < 6) text.push_back(CHAR_PAD);
                    else text.push_back(8'($urandom_range(0, 255)));
                end
            end
        endcase
        foreach (text[i]) send_char(text[i], i == text.size() - 1, 1'b0, NO_RES);
    endtask

    // Random messages until the item count reaches target; mostly clean encodings.
    task automatic random_messages(input int target, input bit long_hold);
        int  pick;
        int  start;
        bit  hold_done;
        start     = live_items;
        hold_done = 1'b0;
        while (live_items < target) begin
            if (long_hold && !hold_done && live_items > start + 20) begin
                hold_asked++;
                hold_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 65) send_message(MSG_CLEAN);
            else if (pick < 75) send_message(MSG_SHORT_PAD);
            else if (pick < 85) send_message(MSG_EXTRA);
            else send_message(MSG_NOISE);
        end
    endtask

    // Result side: random stalls, one long hold on request, none in the calm part.
    initial begin
        int n;
        byte_if.ready <= 1'b0;
        @(posedge i_clk);
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served++;
                byte_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                byte_if.ready <= 1'b1;
            end else if (!calm_run && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 13);
                byte_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                byte_if.ready <= 1'b1;
            end else begin
                byte_if.ready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest pending one.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n === 1'b1 && byte_if.valid === 1'b1 && byte_if.ready === 1'b1) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("result transaction with nothing pending");
            end else begin
                want = decoded_q.pop_front();
                check_field("data_byte", 32'(byte_if.data_byte), 32'(want.data_byte));
                check_field("byte_valid", 32'(byte_if.byte_valid), 32'(want.byte_valid));
                check_field("message_end", 32'(byte_if.message_end),
                            32'(want.message_end));
                check_field("bad_input", 32'(byte_if.bad_input), 32'(want.bad_input));
            end
        end
    end

    // Main sequence.
    initial begin
        int cur_mode;
        for (int k = 0; k < 256; k++) sym_lut[k] = 7'h40;
        for (int v = 0; v < 64; v++) sym_lut[symbol_char(6'(v))] = {1'b0, 6'(v)};
        errors      = 0;
        live_items  = 0;
        hold_asked  = 0;
        hold_served = 0;
        calm_run    = 1'b0;
        pad_mode    = 1'b1;
        clear_message_state();

        i_rst_n           <= 1'b0;
        char_if.valid     <= 1'b0;
        char_if.char_code <= 8'h00;
        char_if.last_char <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; the register is rewritten whenever the mode column changes.
        cur_mode = -1;
        for (int i = 0; i < N_DIR; i++) begin
            if (int'(dir_rows[i].pad_mode) != cur_mode) begin
                wait_idle();
                set_padding_mode(dir_rows[i].pad_mode);
                @(posedge i_clk);
                cur_mode = int'(dir_rows[i].pad_mode);
            end
            send_char(dir_rows[i].c, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases across both modes; the sender drains fully between them.
        wait_idle();
        set_padding_mode(1'b1);
        @(posedge i_clk);
        random_messages(live_items + 150, 1'b0);

        wait_idle();
        set_padding_mode(1'b0);
        @(posedge i_clk);
        random_messages(live_items + 150, 1'b1);

        wait_idle();
        set_padding_mode(1'b1);
        @(posedge i_clk);
        random_messages(live_items + 80, 1'b0);

        // Last part runs back to back on both sides.
        wait_idle();
        calm_run = 1'b1;
        set_padding_mode(1'b0);
        @(posedge i_clk);
        random_messages(live_items + 70, 1'b0);

        wait_idle();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
